// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: types and codes shared by the sorted priority queue cells and top level
// no dependencies

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int COUNT_OUT_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // relation mode bits
    localparam int MODE_LARGER_FIRST = 0;
    localparam int MODE_NEW_FIRST    = 1;

    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } state_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                     push;
        logic                     pop;
        logic                     search;
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
        logic [MODE_W-1:0]        mode;
    } cell_ctrl_t;

    // what a cell shows to its neighbors
    typedef struct packed {
        logic                     occupied;
        logic                     ahead;
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
    } cell_link_t;

    // true when a held priority is still served before the new one
    function automatic logic stays_ahead(
        input logic signed [DATA_W-1:0] held_p,
        input logic signed [DATA_W-1:0] new_p,
        input logic [MODE_W-1:0]        mode
    );
        logic res;
        if (held_p == new_p) begin
            res = ~mode[MODE_NEW_FIRST];
        end
        else if (mode[MODE_LARGER_FIRST]) begin
            res = (held_p > new_p);
        end
        else begin
            res = (held_p < new_p);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, holding an element, its priority and an occupied flag
// depends on spq_pkg

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t self,
    output logic       match
);

    logic                     occ_reg, occ_next;
    logic signed [DATA_W-1:0] elem_reg, elem_next;
    logic signed [DATA_W-1:0] prio_reg, prio_next;
    logic                     match_reg, match_next;
    logic                     ahead;

    // this slot and every slot in front of it stay ahead of the incoming entry,
    // so the insert point is the first slot that does not
    assign ahead = occ_reg & left.ahead & stays_ahead(prio_reg, ctrl.prio, ctrl.mode);

    // shift, insert, hold or flag a search match
    always_comb
    begin
        occ_next   = occ_reg;
        elem_next  = elem_reg;
        prio_next  = prio_reg;
        match_next = 1'b0;
        if (ctrl.push) begin
            occ_next = occ_reg | left.occupied;
            if (!ahead) begin
                if (left.ahead) begin
                    elem_next = ctrl.elem;
                    prio_next = ctrl.prio;
                end
                else begin
                    elem_next = left.elem;
                    prio_next = left.prio;
                end
            end
        end
        else if (ctrl.pop) begin
            occ_next  = right.occupied;
            elem_next = right.elem;
            prio_next = right.prio;
        end
        else if (ctrl.search) begin
            match_next = occ_reg & (elem_reg == ctrl.elem);
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        prio_reg <= prio_next;
    end

    assign self.occupied = occ_reg;
    assign self.ahead    = ahead;
    assign self.elem     = elem_reg;
    assign self.prio     = prio_reg;
    assign match         = match_reg;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, a chain of spq_cell slots kept sorted by priority
// depends on spq_pkg and spq_cell
//
// channel   direction  signals                                         transfer
// command   in         start, command, element_value, priority_value   start && !busy
// result    out        done, out_element, out_priority, out_valid,     every cycle done is high
//                      entry_count, found, status
// config    in         cfg_we, cfg_wdata (relation_mode)               cfg_we
//
// for every command, at the transfer edge all cells compare against the new priority or
// element at once and shift/insert; the next cycle reduces the match flags and registers
// the result, shown with done in the cycle after that.
// busy is high for the one report cycle; a new command may transfer while done shows.
// reset empties the queue and sets relation_mode to 0; the receiver cannot stall.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic signed [DATA_W-1:0] priority_value,
    input  logic                     cfg_we,
    input  logic [MODE_W-1:0]        cfg_wdata,
    output logic                     done,
    output logic signed [DATA_W-1:0] out_element,
    output logic signed [DATA_W-1:0] out_priority,
    output logic                     out_valid,
    output logic [COUNT_OUT_W-1:0]   entry_count,
    output logic                     found,
    output logic [STAT_W-1:0]        status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                   state_reg, state_next;
    logic [MODE_W-1:0]        mode_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     accept;
    logic                     push_ok, pop_ok;
    cell_ctrl_t               ctrl;
    cell_link_t               links [CAPACITY];
    logic [CAPACITY-1:0]      match_vec;

    // captured per command
    logic                     is_pop_reg;
    logic                     pop_hit_reg;
    logic [STAT_W-1:0]        stat_reg;
    logic signed [DATA_W-1:0] pop_elem_reg;
    logic signed [DATA_W-1:0] pop_prio_reg;

    // result registers
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] res_elem_reg, res_elem_next;
    logic signed [DATA_W-1:0] res_prio_reg, res_prio_next;
    logic                     res_valid_reg, res_valid_next;
    logic                     found_reg, found_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;

    // command decode
    assign push_ok = accept & (command == CMD_PUSH) & (count_reg != CNT_W'(CAPACITY));
    assign pop_ok  = accept & (command == CMD_POP) & (count_reg != '0);

    assign ctrl.push   = push_ok;
    assign ctrl.pop    = pop_ok;
    assign ctrl.search = accept & (command == CMD_SEARCH);
    assign ctrl.elem   = element_value;
    assign ctrl.prio   = priority_value;
    assign ctrl.mode   = mode_reg;

    // the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            cell_link_t left_in, right_in;
            if (gi == 0) begin : g_head
                assign left_in.occupied = 1'b1;
                assign left_in.ahead    = 1'b1;
                assign left_in.elem     = '0;
                assign left_in.prio     = '0;
            end
            else begin : g_mid_l
                assign left_in = links[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign right_in.occupied = 1'b0;
                assign right_in.ahead    = 1'b0;
                assign right_in.elem     = '0;
                assign right_in.prio     = '0;
            end
            else begin : g_mid_r
                assign right_in = links[gi+1];
            end
            spq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .left  (left_in),
                .right (right_in),
                .self  (links[gi]),
                .match (match_vec[gi])
            );
        end
    endgenerate

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // sequencer and result formation
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        res_elem_next  = res_elem_reg;
        res_prio_next  = res_prio_reg;
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = stat_reg;
                found_next  = |match_vec;
                if (is_pop_reg) begin
                    res_valid_next = pop_hit_reg;
                    res_elem_next  = pop_hit_reg ? pop_elem_reg : '0;
                    res_prio_next  = pop_hit_reg ? pop_prio_reg : '0;
                end
                else begin
                    res_valid_next = links[0].occupied;
                    res_elem_next  = links[0].occupied ? links[0].elem : '0;
                    res_prio_next  = links[0].occupied ? links[0].prio : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            mode_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept) begin
            is_pop_reg   <= (command == CMD_POP);
            pop_hit_reg  <= pop_ok;
            pop_elem_reg <= links[0].elem;
            pop_prio_reg <= links[0].prio;
            if (command == CMD_PUSH && !push_ok) begin
                stat_reg <= STATUS_FULL;
            end
            else if (command == CMD_POP && !pop_ok) begin
                stat_reg <= STATUS_EMPTY;
            end
            else begin
                stat_reg <= STATUS_OK;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_elem_reg  <= res_elem_next;
        res_prio_reg  <= res_prio_next;
        res_valid_reg <= res_valid_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
    end

    assign count_ext    = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign done         = done_reg;
    assign out_element  = res_elem_reg;
    assign out_priority = res_prio_reg;
    assign out_valid    = res_valid_reg;
    assign entry_count  = count_ext[COUNT_OUT_W-1:0];
    assign found        = found_reg;
    assign status       = status_reg;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for sorted_priority_queue, push/pop/search traffic under all relation modes
// depends on spq_pkg and sorted_priority_queue; a tracker class predicts every result and checks it

module tb_top;
    import spq_pkg::*;

    localparam int CAPACITY = 64;
    localparam int PHASE_ITEMS = 116;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one expected result transfer
    typedef struct {
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
        logic                     valid;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     hit;
        logic [STAT_W-1:0]        status;
    } queue_result_t;

    // sorted list model plus the fifo of results still owed by the block
    class queue_tracker;
        logic signed [DATA_W-1:0] held_elem [CAPACITY];
        logic signed [DATA_W-1:0] held_prio [CAPACITY];
        int                       held_n;
        logic [MODE_W-1:0]        mode;
        queue_result_t            owed_results[$];
        int errors;
        int n_push, n_full, n_pop, n_empty, n_search, n_hit, n_checked;

        function new();
            held_n = 0;
            mode = '0;
            errors = 0;
            n_push = 0; n_full = 0; n_pop = 0; n_empty = 0;
            n_search = 0; n_hit = 0; n_checked = 0;
        endfunction

        // a held entry keeps its place ahead of a new one with priority new_p
        function bit keeps_place(logic signed [DATA_W-1:0] held_p,
                                 logic signed [DATA_W-1:0] new_p);
            if (held_p == new_p)
                return !mode[MODE_NEW_FIRST];
            if (mode[MODE_LARGER_FIRST])
                return held_p > new_p;
            return held_p < new_p;
        endfunction

        // apply one accepted command and queue the result it owes
        function void note_command(logic [CMD_W-1:0] cmd,
                                   logic signed [DATA_W-1:0] e,
                                   logic signed [DATA_W-1:0] p);
            queue_result_t r;
            int pos;
            r.elem = '0; r.prio = '0; r.valid = 1'b0; r.hit = 1'b0; r.status = STATUS_OK;
            case (cmd)
                CMD_PUSH:
                begin
                    n_push++;
                    if (held_n >= CAPACITY) begin
                        r.status = STATUS_FULL;
                        n_full++;
                    end
                    else begin
                        pos = 0;
                        while (pos < held_n && keeps_place(held_prio[pos], p))
                            pos++;
                        for (int i = held_n; i > pos; i--) begin
                            held_elem[i] = held_elem[i-1];
                            held_prio[i] = held_prio[i-1];
                        end
                        held_elem[pos] = e;
                        held_prio[pos] = p;
                        held_n++;
                    end
                end
                CMD_POP:
                begin
                    n_pop++;
                    if (held_n == 0) begin
                        r.status = STATUS_EMPTY;
                        n_empty++;
                    end
                    else begin
                        r.elem = held_elem[0];
                        r.prio = held_prio[0];
                        r.valid = 1'b1;
                        for (int i = 0; i < held_n - 1; i++) begin
                            held_elem[i] = held_elem[i+1];
                            held_prio[i] = held_prio[i+1];
                        end
                        held_n--;
                    end
                end
                CMD_SEARCH:
                begin
                    n_search++;
                    for (int i = 0; i < held_n; i++)
                        if (held_elem[i] == e)
                            r.hit = 1'b1;
                    if (r.hit)
                        n_hit++;
                end
                default:
                begin
                end
            endcase
            // everything but pop reports the head after the step
            if (cmd != CMD_POP && held_n > 0) begin
                r.elem = held_elem[0];
                r.prio = held_prio[0];
                r.valid = 1'b1;
            end
            r.count = COUNT_OUT_W'(held_n);
            owed_results.push_back(r);
        endfunction

        // compare one result transfer with the oldest owed result
        function void check_result(logic signed [DATA_W-1:0] e, logic signed [DATA_W-1:0] p,
                                   logic v, logic [COUNT_OUT_W-1:0] c, logic f,
                                   logic [STAT_W-1:0] s);
            queue_result_t x;
            if (owed_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                errors++;
                return;
            end
            x = owed_results.pop_front();
            n_checked++;
            if (e !== x.elem) begin
                $error("out_element: expected %0d, actual %0d", x.elem, e);
                errors++;
            end
            if (p !== x.prio) begin
                $error("out_priority: expected %0d, actual %0d", x.prio, p);
                errors++;
            end
            if (v !== x.valid) begin
                $error("out_valid: expected %0d, actual %0d", x.valid, v);
                errors++;
            end
            if (c !== x.count) begin
                $error("entry_count: expected %0d, actual %0d", x.count, c);
                errors++;
            end
            if (f !== x.hit) begin
                $error("found: expected %0d, actual %0d", x.hit, f);
                errors++;
            end
            if (s !== x.status) begin
                $error("status: expected %0d, actual %0d", x.status, s);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] priority_value;
    logic                     cfg_we;
    logic [MODE_W-1:0]        cfg_wdata;
    logic                     done;
    logic signed [DATA_W-1:0] out_element;
    logic signed [DATA_W-1:0] out_priority;
    logic                     out_valid;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     found;
    logic [STAT_W-1:0]        status;

    queue_tracker tracker = new();

    sorted_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .element_value  (element_value),
        .priority_value (priority_value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .out_element    (out_element),
        .out_priority   (out_priority),
        .out_valid      (out_valid),
        .entry_count    (entry_count),
        .found          (found),
        .status         (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("sorted_priority_queue verification failed");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(out_element, out_priority, out_valid, entry_count, found,
                                 status);
    end

    // one command transfer; called and returns on a falling edge
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] e,
                                input logic signed [DATA_W-1:0] p, input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        command = cmd;
        element_value = e;
        priority_value = p;
        do @(posedge clk); while (busy);
        tracker.note_command(cmd, e, p);
        @(negedge clk);
    endtask

    // hold off until every owed result has arrived
    task automatic wait_drained();
        int guard;
        start = 1'b0;
        guard = 0;
        while (tracker.owed_results.size() != 0 && guard < 1000) begin
            @(negedge clk);
            guard++;
        end
        repeat (3) @(negedge clk);
    endtask

    // relation mode write while the block is idle
    task automatic write_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        cfg_we = 1'b1;
        cfg_wdata = m;
        @(posedge clk);
        tracker.mode = m;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // priorities cluster on a few values so ties are common
    function automatic logic signed [DATA_W-1:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $signed($urandom_range(0, 6)) - 3;
        if (sel == 8)
            return {1'b1, {(DATA_W-1){1'b0}}};
        if (sel == 9)
            return {1'b0, {(DATA_W-1){1'b1}}};
        return $urandom;
    endfunction

    // searches mostly look for something held
    function automatic logic signed [DATA_W-1:0] pick_element(input bit for_search);
        if (for_search && tracker.held_n > 0 && $urandom_range(0, 9) < 6)
            return tracker.held_elem[$urandom_range(0, tracker.held_n - 1)];
        if ($urandom_range(0, 9) < 3)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    initial
    begin
        logic [MODE_W-1:0] mode_plan [8];
        logic [CMD_W-1:0]  cmd;
        int push_pct;
        int sel;
        bit burst;

        mode_plan = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd0};
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_PUSH;
        element_value = '0;
        priority_value = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty queue cases, field extremes, ties, search hit and miss
        send_command(CMD_POP, 32'sd0, 32'sd0, 0);
        send_command(CMD_SEARCH, 32'sd0, 32'sd0, 1);
        send_command(CMD_UNUSED, 32'sd0, 32'sd0, 0);
        send_command(CMD_PUSH, 32'sd5, 32'sd10, 2);
        send_command(CMD_PUSH, 32'h8000_0000, 32'h8000_0000, 0);
        send_command(CMD_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_command(CMD_PUSH, 32'sd7, 32'sd10, 3);
        send_command(CMD_PUSH, 32'sd8, 32'sd0, 0);
        send_command(CMD_PUSH, -32'sd1, -32'sd1, 0);
        send_command(CMD_SEARCH, 32'sd7, 32'sd0, 0);
        send_command(CMD_SEARCH, 32'sd12345, 32'sd0, 4);
        send_command(CMD_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        repeat (7) send_command(CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 2));
        send_command(CMD_SEARCH, 32'sd5, 32'sd0, 0);

        // random phases, one relation mode each, traffic biased to fill, mix or drain
        for (int ph = 0; ph < 8; ph++) begin
            write_mode(mode_plan[ph]);
            push_pct = (ph % 3 == 0) ? 80 : ((ph % 3 == 1) ? 50 : 25);
            burst = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 16 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                sel = $urandom_range(0, 99);
                if (sel < push_pct) begin
                    cmd = CMD_PUSH;
                end
                else begin
                    sel = $urandom_range(0, 99);
                    cmd = (sel < 4) ? CMD_UNUSED : ((sel < 36) ? CMD_SEARCH : CMD_POP);
                end
                send_command(cmd, pick_element(cmd == CMD_SEARCH), pick_priority(),
                             burst ? 0 : $urandom_range(0, 14));
            end
        end

        // drain and close out
        wait_drained();
        repeat (4) @(negedge clk);
        if (tracker.owed_results.size() != 0) begin
            $error("%0d results never arrived", tracker.owed_results.size());
            tracker.errors++;
        end
        $display("covered %0d pushes (%0d on full), %0d pops (%0d on empty), %0d searches (%0d hits)",
                 tracker.n_push, tracker.n_full, tracker.n_pop, tracker.n_empty,
                 tracker.n_search, tracker.n_hit);
        $display("all four relation modes run, %0d results checked", tracker.n_checked);
        if (tracker.errors == 0)
            $display("sorted_priority_queue verification clean");
        else
            $display("sorted_priority_queue verification failed");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/tb_top.sv
